// ----- rtl/mmt_pkg.sv -----
// ----------------------------------------------------------------------------
// mmt_pkg
// Types, register layout and reset constants shared by the masked mode
// transition block, its channel interfaces and its submodules.
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int MASK_GROUPS  = 2;
    localparam int GROUP_W      = 8;
    localparam int MASK_W       = 16;
    localparam int NIBBLE_W     = 4;
    localparam int NIBBLES      = MASK_W / NIBBLE_W;
    localparam int NIB_IDX_W    = $clog2(NIBBLES);
    localparam int ADDR_W       = 8;
    // Half addresses at or above this limit are rejected.
    localparam int ADDR_LIMIT   = (2 * MASK_GROUPS < NIBBLES) ? 2 * MASK_GROUPS : NIBBLES;
    localparam int ROW_W        = 33;
    localparam int ROW_ONES_LSB = 0;
    localparam int ROW_ZERO_LSB = 16;
    localparam int ROW_TGT_BIT  = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 33;

    localparam logic [ROW_W-1:0]  ROTATE_ROW_RST     = 33'h1_0001_FFFF;
    localparam logic [ROW_W-1:0]  STATIONARY_ROW_RST = 33'h0_0001_FFFF;
    localparam logic [MASK_W-1:0] RETAIN_MASK_RST    = 16'hF0FF;

    localparam logic MODE_ROTATE     = 1'b0;
    localparam logic MODE_STATIONARY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATE_ROW     = 2'd0,
        CFG_STATIONARY_ROW = 2'd1,
        CFG_RETAIN_MASK    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   first_half_addr;
        logic [NIBBLE_W-1:0] first_mask_one;
        logic [NIBBLE_W-1:0] first_mask_zero;
        logic [ADDR_W-1:0]   second_half_addr;
        logic [NIBBLE_W-1:0] second_mask_one;
        logic [NIBBLE_W-1:0] second_mask_zero;
    } cmd_t;

    typedef struct packed {
        logic              mode_now;
        logic              mode_switched;
        logic [MASK_W-1:0] mask_now;
        logic              bad_address;
    } rsp_t;

    typedef struct packed {
        logic [ROW_W-1:0]  rotate_row;
        logic [ROW_W-1:0]  stationary_row;
        logic [MASK_W-1:0] retain_mask;
    } cfg_regs_t;

endpackage

// ----- rtl/mmt_channels.sv -----
// ----------------------------------------------------------------------------
// mmt channel interfaces
// Valid/ready channels for commands, responses and register writes.
// ----------------------------------------------------------------------------
interface mmt_cmd_if;
    import mmt_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmt_rsp_if;
    import mmt_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmt_cfg_if;
    import mmt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mmt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mmt_cfg_regs
// Holds the two mode rows and the retain mask, written over the config port.
// ----------------------------------------------------------------------------
module mmt_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    mmt_cfg_if.sink            cfg,
    output mmt_pkg::cfg_regs_t regs
);
    import mmt_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;
    logic      wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_ROTATE_ROW:     regs_next.rotate_row     = cfg.data[ROW_W-1:0];
                CFG_STATIONARY_ROW: regs_next.stationary_row = cfg.data[ROW_W-1:0];
                CFG_RETAIN_MASK:    regs_next.retain_mask    = cfg.data[MASK_W-1:0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.rotate_row     <= ROTATE_ROW_RST;
            regs_reg.stationary_row <= STATIONARY_ROW_RST;
            regs_reg.retain_mask    <= RETAIN_MASK_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- rtl/mmt_nibble_upd.sv -----
// ----------------------------------------------------------------------------
// mmt_nibble_upd
// Applies one nibble update to the condition mask: per bit, both masks set
// sets, both clear clears, and a mixed pair holds.
// ----------------------------------------------------------------------------
module mmt_nibble_upd (
    input  logic [mmt_pkg::MASK_W-1:0]   mask_in,
    input  logic [mmt_pkg::ADDR_W-1:0]   half_addr,
    input  logic [mmt_pkg::NIBBLE_W-1:0] mask_one,
    input  logic [mmt_pkg::NIBBLE_W-1:0] mask_zero,
    output logic [mmt_pkg::MASK_W-1:0]   mask_out,
    output logic                         bad
);
    import mmt_pkg::*;

    logic [NIB_IDX_W-1:0] nib_sel;

    assign bad     = (half_addr >= ADDR_W'(ADDR_LIMIT));
    assign nib_sel = half_addr[NIB_IDX_W-1:0];

    always_comb
    begin
        mask_out = mask_in;
        for (int n = 0; n < NIBBLES; n++)
        begin
            if (!bad && (nib_sel == NIB_IDX_W'(n)))
            begin
                // Majority of old bit, ones and zeros: agreement wins, else hold.
                mask_out[n*NIBBLE_W +: NIBBLE_W] =
                    (mask_in[n*NIBBLE_W +: NIBBLE_W] & mask_one) |
                    (mask_in[n*NIBBLE_W +: NIBBLE_W] & mask_zero) |
                    (mask_one & mask_zero);
            end
        end
    end

endmodule

// ----- rtl/mmt_mode_step.sv -----
// ----------------------------------------------------------------------------
// mmt_mode_step
// Combinational step for one command: both nibble updates, the row match
// for the current mode and the optional switch that clears unretained bits.
// ----------------------------------------------------------------------------
module mmt_mode_step (
    input  mmt_pkg::cmd_t              cmd,
    input  mmt_pkg::cfg_regs_t         regs,
    input  logic [mmt_pkg::MASK_W-1:0] mask_cur,
    input  logic                       mode_cur,
    output logic [mmt_pkg::MASK_W-1:0] mask_new,
    output logic                       mode_new,
    output mmt_pkg::rsp_t              rsp
);
    import mmt_pkg::*;

    logic [MASK_W-1:0] mask_a;
    logic [MASK_W-1:0] mask_b;
    logic              bad_a;
    logic              bad_b;
    logic [ROW_W-1:0]  row;
    logic [MASK_W-1:0] row_ones;
    logic [MASK_W-1:0] row_zeros;
    logic              row_hit;
    logic              do_switch;

    mmt_nibble_upd u_upd_first (
        .mask_in   (mask_cur),
        .half_addr (cmd.first_half_addr),
        .mask_one  (cmd.first_mask_one),
        .mask_zero (cmd.first_mask_zero),
        .mask_out  (mask_a),
        .bad       (bad_a)
    );

    mmt_nibble_upd u_upd_second (
        .mask_in   (mask_a),
        .half_addr (cmd.second_half_addr),
        .mask_one  (cmd.second_mask_one),
        .mask_zero (cmd.second_mask_zero),
        .mask_out  (mask_b),
        .bad       (bad_b)
    );

    assign row       = (mode_cur == MODE_STATIONARY) ? regs.stationary_row : regs.rotate_row;
    assign row_ones  = row[ROW_ONES_LSB +: MASK_W];
    assign row_zeros = row[ROW_ZERO_LSB +: MASK_W];
    // Every set bit must be allowed by ones, every clear bit by a clear zeros bit.
    assign row_hit   = &((mask_b & row_ones) | (~mask_b & ~row_zeros));
    assign do_switch = row_hit && (row[ROW_TGT_BIT] != mode_cur);

    assign mode_new = do_switch ? row[ROW_TGT_BIT] : mode_cur;
    assign mask_new = do_switch ? (mask_b & regs.retain_mask) : mask_b;

    assign rsp.mode_now      = mode_new;
    assign rsp.mode_switched = do_switch;
    assign rsp.mask_now      = mask_new;
    assign rsp.bad_address   = bad_a || bad_b;

endmodule

// ----- rtl/masked_mode_transition_fsm.sv -----
// ----------------------------------------------------------------------------
// masked_mode_transition_fsm
// Condition mask with nibble updates and a two-mode transition table.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on cmd, one beat per item with two nibble updates. Each
// command produces exactly one beat on rsp with the resulting mode, a switch
// flag, the updated mask and a bad address flag.
// Register writes use cfg, which is always ready; write only while the block
// holds no command and no undelivered response.
// A command accepted on cmd is registered in the input register, evaluated
// against the state registers, and its response is registered in the
// output register that drives rsp. Throughput: one command per cycle while
// rsp is ready; the loop through the mask and mode registers is shallow logic.
// A stalled rsp holds its beat; one more command may wait in the input
// register, after which cmd.ready drops until rsp is taken.
// Reset clears the mask, selects rotate mode, empties both stages and loads
// the row and retain registers with their default values.
// ----------------------------------------------------------------------------
module masked_mode_transition_fsm (
    input  logic    clk,
    input  logic    rst_n,
    mmt_cmd_if.sink cmd,
    mmt_rsp_if.source rsp,
    mmt_cfg_if.sink cfg
);
    import mmt_pkg::*;

    cfg_regs_t         regs;
    logic              in_valid_reg;
    logic              in_valid_next;
    cmd_t              in_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              out_data_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic              mode_reg;
    logic              mode_next;
    logic [MASK_W-1:0] step_mask;
    logic              step_mode;
    rsp_t              step_rsp;
    logic              out_free;
    logic              advance;
    logic              cmd_take;

    mmt_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mmt_mode_step u_mode_step (
        .cmd      (in_data_reg),
        .regs     (regs),
        .mask_cur (mask_reg),
        .mode_cur (mode_reg),
        .mask_new (step_mask),
        .mode_new (step_mode),
        .rsp      (step_rsp)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;
    assign cmd_take  = cmd.valid && cmd.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        in_valid_next  = cmd.ready ? cmd.valid : in_valid_reg;
        out_valid_next = out_free ? in_valid_reg : out_valid_reg;
        mask_next      = advance ? step_mask : mask_reg;
        mode_next      = advance ? step_mode : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            mode_reg      <= MODE_ROTATE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            mode_reg      <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_data_reg <= cmd.data;
        end
        if (advance)
        begin
            out_data_reg <= step_rsp;
        end
    end

    // The pending response always mirrors the state it left behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (mode_reg == out_data_reg.mode_now) &&
                          (mask_reg == out_data_reg.mask_now))
        else $error("state registers disagree with pending response");

    // A switch leaves only retained bits set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.mode_switched) |->
            ((out_data_reg.mask_now & ~regs.retain_mask) == '0))
        else $error("switched response keeps bits outside retain mask");

    // A switch always flips the mode register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_rsp.mode_switched) |=> (mode_reg != $past(mode_reg)))
        else $error("mode switch did not change the mode");

    // With both stages full and the output stalled, no command is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !rsp.ready) |-> !cmd.ready)
        else $error("command accepted while pipeline is full");

endmodule

// ----- tb/sv/masked_mode_transition_fsm_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_mode_transition_fsm_test
// Self-checking bench for the masked mode transition block. Commands carry
// two nibble updates each. A scoreboard object keeps its own copy of the
// condition mask, the mode and the registers, and it predicts one response
// per accepted command. Every response beat is compared field by field.
// Register settings change between phases while the block is idle. Both
// sides stall at random, and the bench applies backpressure.
// ----------------------------------------------------------------------------
module masked_mode_transition_fsm_test;
    import mmt_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int MAX_GAP       = 16;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 3;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 120;
    localparam int CYCLE_LIMIT   = 400000;

    // Index 3 has no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam logic [NIBBLE_W-1:0] NIB_NONE = 4'h0;
    localparam logic [NIBBLE_W-1:0] NIB_ALL  = 4'hF;

    class mode_scoreboard;
        logic [ROW_W-1:0]  rotate_row;
        logic [ROW_W-1:0]  stationary_row;
        logic [MASK_W-1:0] retain;
        logic [MASK_W-1:0] cond_mask;
        logic              mode;
        rsp_t              pending_rsp[$];
        int                mismatches;
        int                results_seen;
        int                switches;
        int                bad_items;

        function new();
            rotate_row     = ROTATE_ROW_RST;
            stationary_row = STATIONARY_ROW_RST;
            retain         = RETAIN_MASK_RST;
            cond_mask      = '0;
            mode           = MODE_ROTATE;
            mismatches     = 0;
            results_seen   = 0;
            switches       = 0;
            bad_items      = 0;
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction

        function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ROTATE_ROW:     rotate_row = val[ROW_W-1:0];
                CFG_STATIONARY_ROW: stationary_row = val[ROW_W-1:0];
                CFG_RETAIN_MASK:    retain = val[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the half address is in range and the update applied.
        function bit merge_nibble(logic [ADDR_W-1:0] addr, logic [NIBBLE_W-1:0] ones,
                                  logic [NIBBLE_W-1:0] zeros);
            logic [MASK_W-1:0] set_bits;
            logic [MASK_W-1:0] clr_bits;
            int                sh;
            if (addr >= ADDR_LIMIT)
                return 1'b0;
            sh = int'(addr) * NIBBLE_W;
            set_bits = '0;
            clr_bits = '0;
            set_bits[NIBBLE_W-1:0] = ones & zeros;
            clr_bits[NIBBLE_W-1:0] = ~ones & ~zeros;
            set_bits = set_bits << sh;
            clr_bits = clr_bits << sh;
            cond_mask = (cond_mask & ~clr_bits) | set_bits;
            return 1'b1;
        endfunction

        function void take_command(cmd_t c);
            rsp_t              r;
            logic [ROW_W-1:0]  row;
            logic [MASK_W-1:0] need_one;
            logic [MASK_W-1:0] need_zero;
            bit                ok_a;
            bit                ok_b;
            ok_a = merge_nibble(c.first_half_addr, c.first_mask_one, c.first_mask_zero);
            ok_b = merge_nibble(c.second_half_addr, c.second_mask_one, c.second_mask_zero);
            r.bad_address   = !(ok_a && ok_b);
            r.mode_switched = 1'b0;
            row = (mode == MODE_STATIONARY) ? stationary_row : rotate_row;
            need_one  = row[ROW_ONES_LSB +: MASK_W];
            need_zero = row[ROW_ZERO_LSB +: MASK_W];
            // Every bit must pass: a set bit needs its ones bit, a clear bit
            // needs its zeros bit clear.
            if (&((cond_mask & need_one) | (~cond_mask & ~need_zero))
                && row[ROW_TGT_BIT] != mode)
            begin
                mode = row[ROW_TGT_BIT];
                cond_mask = cond_mask & retain;
                r.mode_switched = 1'b1;
                switches++;
            end
            if (r.bad_address)
                bad_items++;
            r.mode_now = mode;
            r.mask_now = cond_mask;
            pending_rsp.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
            $display("ERROR beat %0d: %s got %0h expected %0h", results_seen, what, got_v,
                     want_v);
            mismatches++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            results_seen++;
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected beat, mask_now", 32'(got.mask_now), '0);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.mode_now !== want.mode_now)
                    report_mismatch("mode_now", 32'(got.mode_now), 32'(want.mode_now));
                if (got.mode_switched !== want.mode_switched)
                    report_mismatch("mode_switched", 32'(got.mode_switched),
                                    32'(want.mode_switched));
                if (got.mask_now !== want.mask_now)
                    report_mismatch("mask_now", 32'(got.mask_now), 32'(want.mask_now));
                if (got.bad_address !== want.bad_address)
                    report_mismatch("bad_address", 32'(got.bad_address),
                                    32'(want.bad_address));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   reg_writes = 0;
    bit   tx_idle = 1'b0;
    bit   rx_idle = 1'b0;
    bit   rx_long_hold = 1'b0;

    mode_scoreboard sb = new();

    mmt_cmd_if cmd_ch ();
    mmt_rsp_if rsp_ch ();
    mmt_cfg_if cfg_ch ();

    masked_mode_transition_fsm u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("masked_mode_transition_fsm verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.data);
    end

    // Response side: random stalls while rx_idle is set, or one long hold on request.
    initial
    begin : rsp_taker
        int hold;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_long_hold)
            begin
                hold = LONG_HOLD;
                rx_long_hold = 1'b0;
            end
            else
            begin
                hold = rx_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    function automatic int next_gap(bit idle);
        return idle ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    function automatic cmd_t make_cmd(logic [ADDR_W-1:0] a1, logic [NIBBLE_W-1:0] o1,
                                      logic [NIBBLE_W-1:0] z1, logic [ADDR_W-1:0] a2,
                                      logic [NIBBLE_W-1:0] o2, logic [NIBBLE_W-1:0] z2);
        cmd_t c;
        c.first_half_addr  = a1;
        c.first_mask_one   = o1;
        c.first_mask_zero  = z1;
        c.second_half_addr = a2;
        c.second_mask_one  = o2;
        c.second_mask_zero = z2;
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        int roll;
        roll = int'($urandom_range(0, 19));
        if (roll < 18)
            return ADDR_W'($urandom_range(0, ADDR_LIMIT - 1));
        return ADDR_W'($urandom_range(ADDR_LIMIT, 255));
    endfunction

    // Ones and zeros nibbles: pure set/clear, pure hold, or a random mix.
    function automatic logic [2*NIBBLE_W-1:0] pick_nibbles();
        logic [NIBBLE_W-1:0] ones;
        logic [NIBBLE_W-1:0] zeros;
        ones = NIBBLE_W'($urandom);
        case ($urandom_range(0, 2))
            0: zeros = ones;
            1: zeros = ~ones;
            default: zeros = NIBBLE_W'($urandom);
        endcase
        return {ones, zeros};
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        c.first_half_addr = pick_addr();
        {c.first_mask_one, c.first_mask_zero} = pick_nibbles();
        c.second_half_addr = pick_addr();
        {c.second_mask_one, c.second_mask_zero} = pick_nibbles();
        return c;
    endfunction

    // Dense ones and sparse zeros keep matches frequent enough to switch modes.
    function automatic logic [ROW_W-1:0] random_row();
        logic [MASK_W-1:0] ones_m;
        logic [MASK_W-1:0] zeros_m;
        ones_m = MASK_W'($urandom | $urandom | $urandom);
        case ($urandom_range(0, 2))
            0: zeros_m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            1: zeros_m = MASK_W'($urandom & $urandom & $urandom);
            default: zeros_m = MASK_W'($urandom);
        endcase
        return {1'($urandom), zeros_m, ones_m};
    endfunction

    task automatic send_command(input cmd_t c, input int gap);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        sb.take_command(c);
    endtask

    // Leaves cfg.valid high; end_writes lowers it after the last beat.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.take_config(idx, val);
        reg_writes++;
    endtask

    task automatic end_writes();
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic quiesce();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        rst_n        <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset rows: either mode leaves once bit 0 of the mask is set.
        send_command(make_cmd(8'd0, NIB_NONE, NIB_NONE, 8'd1, NIB_NONE, NIB_NONE), 0);
        send_command(make_cmd(8'd1, NIB_ALL, NIB_ALL, 8'd2, NIB_ALL, NIB_NONE), 0);
        send_command(make_cmd(8'd3, NIB_ALL, NIB_ALL, 8'd2, NIB_ALL, NIB_ALL), 0);
        send_command(make_cmd(8'd0, 4'h1, 4'h1, 8'd255, NIB_ALL, NIB_ALL), 0);
        send_command(make_cmd(8'd4, NIB_ALL, NIB_ALL, 8'd0, NIB_NONE, NIB_ALL), 0);
        send_command(make_cmd(8'd255, NIB_NONE, NIB_NONE, 8'd128, NIB_ALL, NIB_ALL), 0);
        send_command(make_cmd(8'd2, 4'h5, 4'h5, 8'd3, 4'hA, 4'hA), 0);
        send_command(make_cmd(8'd1, 4'hC, 4'h3, 8'd0, 4'h3, 4'hC), 0);
        send_command(make_cmd(8'd0, NIB_ALL, NIB_ALL, 8'd3, NIB_NONE, NIB_NONE), 0);
        send_command(make_cmd(8'd3, NIB_ALL, NIB_ALL, 8'd1, NIB_ALL, NIB_ALL), 0);
        send_command(make_cmd(8'd2, NIB_NONE, NIB_NONE, 8'd0, NIB_NONE, NIB_NONE), 0);
        send_command(make_cmd(8'd0, NIB_ALL, NIB_ALL, 8'd1, NIB_ALL, NIB_ALL), 0);
        send_command(make_cmd(8'd3, NIB_NONE, NIB_NONE, 8'd2, NIB_NONE, NIB_NONE), 0);
        send_command(make_cmd(8'h55, NIB_ALL, NIB_ALL, 8'd0, NIB_ALL, NIB_ALL), 0);
        send_command(make_cmd(8'hAA, NIB_NONE, NIB_NONE, 8'd2, NIB_ALL, NIB_ALL), 0);

        // Both rows target rotate and match only an empty mask, so clearing the
        // mask switches stationary mode to rotate; later matches cause no switch.
        quiesce();
        write_reg(CFG_ROTATE_ROW, '0);
        write_reg(CFG_STATIONARY_ROW, '0);
        end_writes();
        send_command(make_cmd(8'd0, NIB_NONE, NIB_NONE, 8'd1, NIB_NONE, NIB_NONE), 0);
        send_command(make_cmd(8'd2, NIB_NONE, NIB_NONE, 8'd3, NIB_NONE, NIB_NONE), 0);
        send_command(make_cmd(8'd1, NIB_NONE, NIB_ALL, 8'd2, NIB_ALL, NIB_NONE), 0);

        for (int p = 0; p < PHASES; p++)
        begin
            quiesce();
            case (p)
                0:
                begin
                    write_reg(CFG_ROTATE_ROW, '0);
                    write_reg(CFG_STATIONARY_ROW, '0);
                    write_reg(CFG_RETAIN_MASK, '0);
                    write_reg(CFG_SPARE_IDX, CFG_DATA_W'({$urandom, $urandom}));
                end
                1:
                begin
                    write_reg(CFG_ROTATE_ROW, '1);
                    write_reg(CFG_STATIONARY_ROW, '1);
                    write_reg(CFG_RETAIN_MASK, CFG_DATA_W'(16'hFFFF));
                end
                2:
                begin
                    write_reg(CFG_ROTATE_ROW, ROTATE_ROW_RST);
                    write_reg(CFG_STATIONARY_ROW, STATIONARY_ROW_RST);
                    write_reg(CFG_RETAIN_MASK, CFG_DATA_W'(RETAIN_MASK_RST));
                end
                default:
                begin
                    write_reg(CFG_ROTATE_ROW, random_row());
                    write_reg(CFG_STATIONARY_ROW, random_row());
                    write_reg(CFG_RETAIN_MASK, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
                end
            endcase
            end_writes();

            tx_idle = (p % 3) != 0;
            rx_idle = (p % 4) != 1;
            // The response side holds off while commands keep coming, so the
            // block fills up and drops cmd.ready.
            if (p == 4)
            begin
                tx_idle = 1'b0;
                rx_long_hold = 1'b1;
            end

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 6 && i == PHASE_ITEMS / 2)
                    quiesce();
                send_command(random_command(), next_gap(tx_idle));
            end
        end

        quiesce();
        repeat (8) @(posedge clk);
        $display("Checked %0d response beats across %0d register settings, %0d writes.",
                 sb.results_seen, PHASES + 1, reg_writes);
        $display("Saw %0d mode switches and %0d commands with out-of-range addresses.",
                 sb.switches, sb.bad_items);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("masked_mode_transition_fsm verification clean");
        else
            $display("masked_mode_transition_fsm verification failed");
        $finish;
    end

endmodule

// ----- masked_mode_transition_fsm.f -----
rtl/mmt_pkg.sv
rtl/mmt_channels.sv
rtl/mmt_cfg_regs.sv
rtl/mmt_nibble_upd.sv
rtl/mmt_mode_step.sv
rtl/masked_mode_transition_fsm.sv
tb/sv/masked_mode_transition_fsm_test.sv
